// ===== rtl/first_fit_heap_allocator_unit_defines.svh =====
// Assertion macros for the first-fit heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define FFH_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// next-cycle implication
`define FFH_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// ===== rtl/ffha_pkg.sv =====
// ---------------------------------------------------------------------------
// ffha_pkg
// Shared constants and codes for the first-fit heap allocator.
// ---------------------------------------------------------------------------
`default_nettype none
package ffha_pkg;
  localparam int ALIGN_BYTES_DEF  = 4;
  localparam int HEADER_BYTES_DEF = 12;
  localparam int MAX_BLOCKS_DEF   = 64;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_INIT   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;
  localparam logic [1:0] ST_NULL    = 2'd3;

  localparam logic CFG_REGION_START  = 1'b0;
  localparam logic CFG_REGION_LENGTH = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/ffha_ram.sv =====
// ---------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap allocator with split on alloc and coalescing on free.
// ---------------------------------------------------------------------------
// Channel   | Handshake        | Payload
// request   | valid / stall    | req_type, alloc_bytes, release_address
// result    | out_valid/out_stall | status, payload_address
// config    | cfg_we           | cfg_index, cfg_data
//
// One request at a time. A walk reads the table entries one after another
// (issue, then registered RAM read), through the single table RAM read port.
// Alloc: search walk, plus one shift pass (a read and a write per moved entry) on split.
// Free: search walk, then one compaction pass over the table doing the merges.
// Init, zero-size alloc, null free: no walk, straight to the result.
// Reset (rst, synchronous) empties the table; no clearing pass is needed.
// While the result waits under out_stall, no new request is taken.
// ---------------------------------------------------------------------------
`default_nettype none
module first_fit_heap_allocator_unit #(
  parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] alloc_bytes,
  input  wire logic [31:0] release_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      payload_address,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import ffha_pkg::*;
  `include "first_fit_heap_allocator_unit_defines.svh"

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
  localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);
  localparam logic [33:0] AM1   = 34'(ALIGN_BYTES - 1);
  localparam logic [33:0] SPLIT_MIN = 34'(HEADER_BYTES + ALIGN_BYTES);

  // state codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRD   = 4'd1;  // search: issue read
  localparam logic [3:0] S_SCHK  = 4'd2;  // search: examine entry
  localparam logic [3:0] S_SHRD  = 4'd3;  // shift up: read k-1
  localparam logic [3:0] S_SHWR  = 4'd4;  // shift up: write k
  localparam logic [3:0] S_SPL1  = 4'd5;  // write remainder entry
  localparam logic [3:0] S_SPL2  = 4'd6;  // write allocated entry (shrunken on split)
  localparam logic [3:0] S_MRD   = 4'd7;  // merge: issue read
  localparam logic [3:0] S_MCHK  = 4'd8;  // merge: combine
  localparam logic [3:0] S_MFIN  = 4'd9;  // merge: write last
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]    state;
  logic [31:0]   region_start, region_length;
  logic [CW-1:0] count;
  logic [31:0]   base;
  logic [1:0]    req;
  logic [32:0]   need;        // rounded size (may reach 2^32), or pointer on free
  logic [31:0]   hdr;
  logic [CW-1:0] idx;         // read index / shift k
  logic [CW-1:0] hit;         // found entry
  logic [CW-1:0] wr;          // compaction write index
  logic [31:0]   acc_size;
  logic          acc_used;
  logic [31:0]   rem_size;
  logic [1:0]    res_status;
  logic [31:0]   res_addr;

  // table RAM: {used, size}
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [32:0]   ram_wdata, ram_rdata;

  ffha_ram #(.WIDTH(33), .DEPTH(MAX_BLOCKS)) u_table (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  wire [31:0] rd_size = ram_rdata[31:0];
  wire        rd_used = ram_rdata[32];
  wire        accept  = valid && !stall;

  assign stall           = (state != S_IDLE);
  assign out_valid       = (state == S_DONE);
  assign status          = res_status;
  assign payload_address = res_addr;

  // init and alloc-size arithmetic
  wire [33:0] al_full = ({2'b0, region_start} + AM1) / 34'(ALIGN_BYTES) * 34'(ALIGN_BYTES);
  wire [33:0] adj     = al_full - {2'b0, region_start};
  wire [33:0] len     = ({2'b0, region_length} > adj) ? {2'b0, region_length} - adj : 34'd0;
  wire [33:0] need_f  = ({2'b0, alloc_bytes} + AM1) / 34'(ALIGN_BYTES) * 34'(ALIGN_BYTES);

  // arithmetic on the current entry: remainder, next header, payload address
  wire [33:0] fit_rem = {2'b0, rd_size} - {1'b0, need};
  wire [31:0] hdr_nxt = hdr + 32'(HEADER_BYTES) + rd_size;
  wire [31:0] payload = hdr + 32'(HEADER_BYTES);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr[AW-1:0];
    ram_wdata = {acc_used, acc_size};
    ram_raddr = idx[AW-1:0];
    unique case (state)
      S_IDLE:  ram_we = accept && (req_type == REQ_INIT) && (len >= HDR34);
      S_SHWR:  begin
        ram_we = 1'b1; ram_waddr = idx[AW-1:0]; ram_wdata = ram_rdata;
      end
      S_SHRD:  ram_raddr = AW'(idx - 1'b1);
      S_SPL1:  begin
        ram_we = 1'b1; ram_waddr = AW'(hit + 1'b1); ram_wdata = {1'b0, rem_size};
      end
      S_SPL2:  begin
        ram_we = 1'b1; ram_waddr = hit[AW-1:0]; ram_wdata = {1'b1, need[31:0]};
      end
      S_MFIN:  ram_we = 1'b1;
      S_SCHK:  begin
        ram_we = 1'b0;
      end
      // flush the pending entry when it cannot merge with the current one
      S_MCHK:  ram_we = (idx != '0) && (acc_used || ((idx != hit) && rd_used));
      default: ram_we = 1'b0;
    endcase
    if (state == S_IDLE) begin
      ram_waddr = '0;
      ram_wdata = {1'b0, 32'(len - HDR34)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; region_start <= '0; region_length <= '0;
      count <= '0; base <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_REGION_START) region_start <= cfg_data;
        else region_length <= cfg_data;
      end
      unique case (state)
        S_IDLE: if (accept) begin
          req <= req_type; res_addr <= '0; res_status <= ST_DONE;
          hdr <= base; idx <= '0;
          priority case (req_type)
            REQ_INIT: begin
              base  <= al_full[31:0];
              count <= (len >= HDR34) ? CW'(1) : '0;
              state <= S_DONE;
            end
            REQ_ALLOC: begin
              need <= need_f[32:0];
              if (alloc_bytes == '0) begin
                res_status <= ST_NOFIT; state <= S_DONE;
              end else begin
                state <= S_SRD;
              end
            end
            REQ_FREE: begin
              need <= {1'b0, release_address};
              if (release_address == '0) begin
                res_status <= ST_NULL; state <= S_DONE;
              end else begin
                state <= S_SRD;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_SRD: begin
          if (idx >= count) begin
            res_status <= (req == REQ_ALLOC) ? ST_NOFIT : ST_BADADDR;
            state <= S_DONE;
          end else begin
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          hit <= idx;
          if (req == REQ_ALLOC && !rd_used && !fit_rem[33]) begin
            res_addr <= payload;
            rem_size <= 32'(fit_rem - HDR34);
            if (fit_rem >= SPLIT_MIN && count < MAXC) begin
              idx <= count; state <= S_SHRD;
            end else begin
              need <= {1'b0, rd_size}; state <= S_SPL2;
            end
          end else if (req == REQ_FREE && {1'b0, payload} == need) begin
            // mark free, then compact the whole table
            acc_size <= rd_size; acc_used <= 1'b0;
            wr <= '0; idx <= '0; state <= S_MRD;
          end else begin
            hdr <= hdr_nxt; idx <= idx + 1'b1; state <= S_SRD;
          end
        end
        S_SHRD: state <= (idx > hit + 1'b1) ? S_SHWR : S_SPL1;
        S_SHWR: begin
          idx <= idx - 1'b1; state <= S_SHRD;
        end
        S_SPL1: begin
          count <= count + 1'b1; state <= S_SPL2;
        end
        S_SPL2: state <= S_DONE;
        S_MRD: state <= (idx >= count) ? S_MFIN : S_MCHK;
        S_MCHK: begin
          // acc holds the pending output entry
          if (idx == '0) begin
            acc_size <= rd_size; acc_used <= (hit == '0) ? 1'b0 : rd_used;
          end else if (!acc_used && !((idx == hit) ? 1'b0 : rd_used)) begin
            acc_size <= acc_size + 32'(HEADER_BYTES) + rd_size;
          end else begin
            wr <= wr + 1'b1;
            acc_size <= rd_size; acc_used <= (idx == hit) ? 1'b0 : rd_used;
          end
          idx <= idx + 1'b1; state <= S_MRD;
        end
        S_MFIN: begin
          count <= wr + 1'b1; state <= S_DONE;
        end
        S_DONE: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFH_ASSERT_IMP(a_cnt_max, clk, rst, 1'b1, count <= MAXC, "entry count beyond table")
  `FFH_ASSERT_NXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status), "result dropped")
  `FFH_ASSERT_IMP(a_busy, clk, rst, out_valid, stall, "request taken while result pending")
endmodule
`default_nettype wire

// ===== tb/first_fit_heap_allocator_checker.sv =====
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_checker
// Watches the request, result and config ports, keeps its own copy of the
// block table and checks every result against the predicted one, in order.
// ---------------------------------------------------------------------------
`default_nettype none
module first_fit_heap_allocator_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  input  wire logic        stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] alloc_bytes,
  input  wire logic [31:0] release_address,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  status,
  input  wire logic [31:0] payload_address,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               outstanding,
  output int               errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  localparam int ALIGN = ALIGN_BYTES_DEF;
  localparam int HDR   = HEADER_BYTES_DEF;
  localparam int DEPTH = MAX_BLOCKS_DEF;
  localparam logic [63:0] MASK = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] addr;
  } alloc_result_t;

  logic [31:0]   blk_size [DEPTH];
  logic          blk_used [DEPTH];
  int            blk_count;
  logic [31:0]   heap_base;
  logic [31:0]   cfg_start, cfg_length;
  alloc_result_t awaited[$];

  assign outstanding = awaited.size();

  function automatic logic [63:0] align_up(logic [63:0] v);
    return ((v + ALIGN - 1) / ALIGN) * ALIGN;
  endfunction

  task automatic coalesce();
    int i;
    i = 0;
    while (i + 1 < blk_count) begin
      if (!blk_used[i] && !blk_used[i+1]) begin
        blk_size[i] = blk_size[i] + 32'(HDR) + blk_size[i+1];
        for (int k = i + 1; k + 1 < blk_count; k++) begin
          blk_size[k] = blk_size[k+1];
          blk_used[k] = blk_used[k+1];
        end
        blk_count--;
      end else begin
        i++;
      end
    end
  endtask

  task automatic predict(input logic [1:0] kind, input logic [31:0] bytes,
                         input logic [31:0] ptr, output alloc_result_t res);
    logic [63:0] hdr, need, rem, al, adj, len;
    bit hit;
    res = '{st: ST_DONE, addr: 32'd0};
    hdr = heap_base;
    hit = 0;
    case (kind)
      REQ_ALLOC: begin
        if (bytes == 0) begin
          res.st = ST_NOFIT;
        end else begin
          need = align_up({32'd0, bytes});
          for (int i = 0; i < blk_count && !hit; i++) begin
            if (!blk_used[i] && {32'd0, blk_size[i]} >= need) begin
              hit = 1;
              rem = {32'd0, blk_size[i]} - need;
              if (rem >= 64'(HDR + ALIGN) && blk_count < DEPTH) begin
                for (int k = blk_count; k > i + 1; k--) begin
                  blk_size[k] = blk_size[k-1];
                  blk_used[k] = blk_used[k-1];
                end
                blk_size[i+1] = 32'(rem - 64'(HDR));
                blk_used[i+1] = 1'b0;
                blk_count++;
                blk_size[i] = need[31:0];
              end
              blk_used[i] = 1'b1;
              res.addr = 32'((hdr + 64'(HDR)) & MASK);
            end else begin
              hdr = (hdr + 64'(HDR) + {32'd0, blk_size[i]}) & MASK;
            end
          end
          if (!hit) res.st = ST_NOFIT;
        end
      end
      REQ_FREE: begin
        if (ptr == 0) begin
          res.st = ST_NULL;
        end else begin
          for (int i = 0; i < blk_count && !hit; i++) begin
            if (((hdr + 64'(HDR)) & MASK) == {32'd0, ptr}) begin
              hit = 1;
              blk_used[i] = 1'b0;
              coalesce();
            end else begin
              hdr = (hdr + 64'(HDR) + {32'd0, blk_size[i]}) & MASK;
            end
          end
          if (!hit) res.st = ST_BADADDR;
        end
      end
      REQ_INIT: begin
        al  = align_up({32'd0, cfg_start});
        adj = al - {32'd0, cfg_start};
        len = ({32'd0, cfg_length} > adj) ? {32'd0, cfg_length} - adj : 64'd0;
        heap_base = al[31:0];
        blk_count = 0;
        if (len >= 64'(HDR)) begin
          blk_size[0] = 32'(len - 64'(HDR));
          blk_used[0] = 1'b0;
          blk_count = 1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    alloc_result_t exp_res, new_res;
    if (rst) begin
      blk_count  = 0;
      heap_base  = '0;
      cfg_start  <= '0;
      cfg_length <= '0;
      errors     <= 0;
      awaited.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $display("%0t unexpected result: status %0d addr %h", $time, status,
                   payload_address);
          errors <= errors + 1;
        end else begin
          exp_res = awaited.pop_front();
          if (status !== exp_res.st || payload_address !== exp_res.addr) begin
            $display("%0t mismatch: expected status %0d addr %h, got status %0d addr %h",
                     $time, exp_res.st, exp_res.addr, status, payload_address);
            errors <= errors + 1;
          end
        end
      end
      if (valid && !stall) begin
        predict(req_type, alloc_bytes, release_address, new_res);
        awaited.push_back(new_res);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_REGION_START) cfg_start <= cfg_data;
        else cfg_length <= cfg_data;
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives requests and heap settings into the first-fit allocator and gives
// the verdict from the checker's error count.
// ---------------------------------------------------------------------------
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        stall;
  logic [1:0]  req_type = REQ_ALLOC;
  logic [31:0] alloc_bytes = '0;
  logic [31:0] release_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] payload_address;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_REGION_START;
  logic [31:0] cfg_data = '0;
  int          outstanding, errors;
  int          send_idle = 0, recv_idle = 0;
  int          cycles = 0;
  logic [31:0] live_ptrs[$];   // granted payload addresses not yet picked for a free, since the last set_heap

  always #10 clk = ~clk;

  first_fit_heap_allocator_unit uut (.*);

  first_fit_heap_allocator_checker chk (.*);

  // receiver back-pressure
  always @(posedge clk) out_stall <= !rst && ($urandom_range(99) < recv_idle);

  // remember granted blocks so most frees hit real ones
  always @(posedge clk)
    if (!rst && out_valid && !out_stall && status == ST_DONE && payload_address != 0)
      live_ptrs.push_back(payload_address);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("first_fit_heap_allocator_unit verification failed");
      $finish;
    end
  end

  // one request; returns at the edge that takes it
  task automatic send(input logic [1:0] kind, input logic [31:0] bytes,
                      input logic [31:0] ptr);
    while ($urandom_range(99) < send_idle) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid           <= 1'b1;
    req_type        <= kind;
    alloc_bytes     <= bytes;
    release_address <= ptr;
    @(negedge clk);
    while (stall) @(negedge clk);
    @(posedge clk);
  endtask

  // drain every outstanding result
  task automatic drain();
    valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_heap(input logic [31:0] start, input logic [31:0] length);
    drain();
    cfg_we <= 1'b1; cfg_index <= CFG_REGION_START;  cfg_data <= start;
    @(posedge clk);
    cfg_index <= CFG_REGION_LENGTH; cfg_data <= length;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_ptrs.delete();
    send(REQ_INIT, $urandom, $urandom);
  endtask

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 32'd0;
    if (r < 73) return $urandom_range(64, 1);
    if (r < 93) return $urandom_range(2000, 1);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_ptr();
    int r, idx;
    logic [31:0] p;
    r = $urandom_range(99);
    if (live_ptrs.size() != 0 && r < 80) begin
      idx = $urandom_range(live_ptrs.size() - 1);
      p = live_ptrs[idx];
      live_ptrs.delete(idx);
      return p;
    end
    if (r < 88) return $urandom;
    if (r < 94) return 32'd0;
    if (live_ptrs.size() != 0) return live_ptrs[0] + 4;
    return $urandom;
  endfunction

  task automatic random_requests(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 52)      send(REQ_ALLOC, pick_size(), $urandom);
      else if (r < 88) send(REQ_FREE, $urandom, pick_ptr());
      else if (r < 91) send(REQ_INIT, $urandom, $urandom);
      else if (r < 93) send(REQ_UNUSED, $urandom, $urandom);
      else             send(REQ_ALLOC, $urandom_range(300, 1), $urandom);
    end
  endtask

  initial begin
    logic [31:0] first_ptr;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: size extremes, every request kind, null and bogus frees
    set_heap(32'h0000_1001, 32'd300);
    send(REQ_ALLOC, 32'd0, 32'd0);
    send(REQ_ALLOC, 32'd1, 32'd0);
    send(REQ_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send(REQ_ALLOC, 32'd7, 32'd0);
    send(REQ_ALLOC, 32'd500, 32'd0);
    send(REQ_FREE, 32'd0, 32'd0);
    send(REQ_FREE, 32'd0, 32'h0000_0003);
    drain();
    first_ptr = live_ptrs.size() ? live_ptrs[0] : 32'h1010;
    send(REQ_FREE, 32'd0, first_ptr);
    send(REQ_FREE, 32'd0, first_ptr);     // already free
    send(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(REQ_ALLOC, 32'd200, 32'd0);      // fits the free tail block, which splits
    set_heap(32'h0000_0003, 32'd12);      // too short after alignment
    send(REQ_ALLOC, 32'd1, 32'd0);
    set_heap(32'hFFFF_FFFD, 32'hFFFF_FFFF); // base wraps to zero
    send(REQ_ALLOC, 32'hFFFF_FF00, 32'd0);
    send(REQ_ALLOC, 32'd4, 32'd0);
    set_heap(32'd0, 32'd0);
    send(REQ_ALLOC, 32'd4, 32'd0);
    send(REQ_FREE, 32'd0, 32'd12);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 14 : (phase == 1) ? 64 : 0;
      recv_idle = (phase == 0) ? 64 : (phase == 1) ? 14 : 0;
      for (int s = 0; s < 3; s++) begin
        case ((phase * 3 + s) % 5)
          0: set_heap($urandom, $urandom_range(3000, 16));
          1: set_heap(32'hFFFF_FFF0, $urandom_range(2000, 100)); // addresses wrap
          2: set_heap($urandom, $urandom_range(600, 12));
          3: set_heap(32'hFFFF_FFFF, 32'hFFFF_FFFF);
          default: set_heap($urandom_range(64), $urandom_range(20000, 1000));
        endcase
        random_requests(80);
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("first_fit_heap_allocator_unit verification clean");
    else $display("first_fit_heap_allocator_unit verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== first_fit_heap_allocator_unit.f =====
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator_unit.sv
tb/first_fit_heap_allocator_checker.sv
tb/testbench.sv
